>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, quiet while reset is low
`define RBSI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define RBSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBSI_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBSI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared widths, types and arithmetic helpers of the ray box slab test
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int OUT_W     = 48;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam int NUM_W     = COORD_W + 1;
    localparam int DEN_W     = COORD_W;
    localparam int QUO_W     = NUM_W + FRAC_W;
    localparam int STEP_BITS = 7;
    localparam int DIV_STG   = (QUO_W + STEP_BITS - 1) / STEP_BITS;
    localparam int QPAD_W    = DIV_STG * STEP_BITS;
    localparam int AXIS_STG  = DIV_STG + 3;
    localparam int TOP_STG   = AXIS_STG + 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [OUT_W-1:0]   t_dist;

    localparam t_dist POS_SAT = {1'b0, {(OUT_W-1){1'b1}}};
    localparam t_dist NEG_SAT = {1'b1, {(OUT_W-1){1'b0}}};

    localparam t_coord BOX_MAX_RST = COORD_W'(64'sd5000 <<< FRAC_W);
    localparam t_coord BOX_MIN_RST = COORD_W'(-(64'sd5000 <<< FRAC_W));

    localparam logic [REG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_Z = 3'd5;

    // partial state of one restoring divider
    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [QPAD_W-1:0] num;
        logic [QPAD_W-1:0] quo;
    } t_div;

    // per-axis flags traveling beside the dividers
    typedef struct packed {
        logic             par;
        logic             inr;
        logic             dneg;
        logic             neg_a;
        logic             neg_b;
        logic [DEN_W-1:0] den;
    } t_side;

    // STEP_BITS quotient bits of restoring division
    function automatic t_div div_step(t_div s, logic [DEN_W-1:0] den);
        t_div           r;
        logic [DEN_W:0] r2;
        r = s;
        for (int i = 0; i < STEP_BITS; i++) begin
            r2    = {r.rem, r.num[QPAD_W-1]};
            r.num = {r.num[QPAD_W-2:0], 1'b0};
            if (r2 >= {1'b0, den}) begin
                r2    = r2 - {1'b0, den};
                r.quo = {r.quo[QPAD_W-2:0], 1'b1};
            end else begin
                r.quo = {r.quo[QPAD_W-2:0], 1'b0};
            end
            r.rem = r2[DEN_W-1:0];
        end
        return r;
    endfunction

    // clamp quotient magnitude to the output range and apply the sign
    function automatic t_dist sat_div(logic [QPAD_W-1:0] quo, logic neg);
        logic [QPAD_W-1:0] lim;
        logic [OUT_W-1:0]  q;
        lim = QPAD_W'({(OUT_W-1){1'b1}}) + QPAD_W'(neg);
        q   = (quo > lim) ? lim[OUT_W-1:0] : quo[OUT_W-1:0];
        return neg ? t_dist'(OUT_W'(0) - q) : t_dist'(q);
    endfunction

endpackage

>>> rtl/core/rbsi_axis.sv
// ----------------------------------------------------------------------------
// rbsi_axis
// near and far slab distances of one axis, pipelined long division
// ----------------------------------------------------------------------------
module rbsi_axis (
    input  logic                              i_clk,
    input  logic [rbsi_pkg::AXIS_STG-1:0]     i_en,
    input  rbsi_pkg::t_coord                  i_lo,
    input  rbsi_pkg::t_coord                  i_hi,
    input  rbsi_pkg::t_coord                  i_o,
    input  rbsi_pkg::t_coord                  i_d,
    output rbsi_pkg::t_dist                   o_near,
    output rbsi_pkg::t_dist                   o_far
);

    localparam int NW = rbsi_pkg::NUM_W;
    localparam int CW = rbsi_pkg::COORD_W;
    localparam int DS = rbsi_pkg::DIV_STG;

    // stage 0: differences and parallel test
    logic signed [NW-1:0] r_lo_diff, r_hi_diff, n_lo_diff, n_hi_diff;
    rbsi_pkg::t_coord     r_d;
    logic                 r_inr, r_dzero;

    assign n_lo_diff = {i_lo[CW-1], i_lo} - {i_o[CW-1], i_o};
    assign n_hi_diff = {i_hi[CW-1], i_hi} - {i_o[CW-1], i_o};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lo_diff <= n_lo_diff;
            r_hi_diff <= n_hi_diff;
            r_d       <= i_d;
            r_inr     <= (i_o >= i_lo) && (i_o <= i_hi);
            r_dzero   <= (i_d == '0);
        end
    end

    // stage 1: magnitudes and result signs
    logic [NW-1:0]              lo_mag, hi_mag;
    logic [rbsi_pkg::DEN_W-1:0] d_mag;
    rbsi_pkg::t_side            n_side;
    rbsi_pkg::t_div             r_div_a [DS+1];
    rbsi_pkg::t_div             r_div_b [DS+1];
    rbsi_pkg::t_side            r_side  [DS+1];

    assign lo_mag = r_lo_diff[NW-1] ? NW'(0) - NW'(r_lo_diff) : NW'(r_lo_diff);
    assign hi_mag = r_hi_diff[NW-1] ? NW'(0) - NW'(r_hi_diff) : NW'(r_hi_diff);
    assign d_mag  = r_d[CW-1] ? rbsi_pkg::DEN_W'(0) - rbsi_pkg::DEN_W'(r_d)
                              : rbsi_pkg::DEN_W'(r_d);

    always_comb begin
        n_side.par   = r_dzero;
        n_side.inr   = r_inr;
        n_side.dneg  = r_d[CW-1];
        n_side.neg_a = r_lo_diff[NW-1] ^ r_d[CW-1];
        n_side.neg_b = r_hi_diff[NW-1] ^ r_d[CW-1];
        n_side.den   = d_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_div_a[0].rem <= '0;
            r_div_a[0].num <= rbsi_pkg::QPAD_W'({lo_mag, {rbsi_pkg::FRAC_W{1'b0}}});
            r_div_a[0].quo <= '0;
            r_div_b[0].rem <= '0;
            r_div_b[0].num <= rbsi_pkg::QPAD_W'({hi_mag, {rbsi_pkg::FRAC_W{1'b0}}});
            r_div_b[0].quo <= '0;
            r_side[0]      <= n_side;
        end
    end

    // division stages
    for (genvar g = 0; g < DS; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en[g+2]) begin
                r_div_a[g+1] <= rbsi_pkg::div_step(r_div_a[g], r_side[g].den);
                r_div_b[g+1] <= rbsi_pkg::div_step(r_div_b[g], r_side[g].den);
                r_side[g+1]  <= r_side[g];
            end
        end
    end

    // last stage: saturate, swap for negative direction, parallel override
    rbsi_pkg::t_dist dist_a, dist_b, n_near, n_far, r_near, r_far;

    assign dist_a = rbsi_pkg::sat_div(r_div_a[DS].quo, r_side[DS].neg_a);
    assign dist_b = rbsi_pkg::sat_div(r_div_b[DS].quo, r_side[DS].neg_b);

    always_comb begin
        if (r_side[DS].par) begin
            n_near = r_side[DS].inr ? rbsi_pkg::NEG_SAT : rbsi_pkg::POS_SAT;
            n_far  = r_side[DS].inr ? rbsi_pkg::POS_SAT : rbsi_pkg::NEG_SAT;
        end else if (r_side[DS].dneg) begin
            n_near = dist_b;
            n_far  = dist_a;
        end else begin
            n_near = dist_a;
            n_far  = dist_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[rbsi_pkg::AXIS_STG-1]) begin
            r_near <= n_near;
            r_far  <= n_far;
        end
    end

    assign o_near = r_near;
    assign o_far  = r_far;

endmodule

>>> rtl/core/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// ray against axis-aligned box, slab method; unless stalled, one ray per clock
// ----------------------------------------------------------------------------
// usage
//  - input channel i_in_valid / o_in_ready carries one ray word: origin and
//    direction, signed Q16.16 per axis; a zero direction axis is parallel
//  - output channel o_out_valid / i_out_ready carries o_hit, o_t_enter and
//    o_t_exit (signed Q32.16, saturated at the 48-bit range ends)
//  - box bounds sit in six apb registers at byte offsets 0..20 (min x,y,z then
//    max x,y,z); write them only while no ray is in flight
//  - pipeline: the accepting edge loads the first of 12 register stages
//    (differences, magnitudes, 7 division stages of 7 quotient bits each,
//    saturate/swap, entry/exit reduce, output register)
//  - throughput: one ray per cycle unless the receiver stalls, set by the
//    fully pipelined dividers (two per axis, six in all)
//  - a stalled receiver freezes only the full stages behind it; bubbles are
//    squeezed out, so o_in_ready stays high until every stage holds a word
//  - reset clears all valid bits and loads the box to +/-5000.0
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_box_slab_intersect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // apb configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rbsi_pkg::ADDR_W-1:0]       paddr,
    input  logic [rbsi_pkg::DATA_W-1:0]       pwdata,
    output logic [rbsi_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    // ray input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_origin_x,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_origin_y,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_origin_z,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_direction_x,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_direction_y,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_direction_z,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic signed [rbsi_pkg::OUT_W-1:0] o_t_enter,
    output logic signed [rbsi_pkg::OUT_W-1:0] o_t_exit
);

    localparam int NS = rbsi_pkg::TOP_STG;
    localparam int AS = rbsi_pkg::AXIS_STG;

    // ------------------------------------------------------------------
    // box registers
    // ------------------------------------------------------------------
    rbsi_pkg::t_coord r_min_x, r_min_y, r_min_z, r_max_x, r_max_y, r_max_z;
    logic             cfg_wr;
    logic [rbsi_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[rbsi_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= rbsi_pkg::BOX_MIN_RST;
            r_min_y <= rbsi_pkg::BOX_MIN_RST;
            r_min_z <= rbsi_pkg::BOX_MIN_RST;
            r_max_x <= rbsi_pkg::BOX_MAX_RST;
            r_max_y <= rbsi_pkg::BOX_MAX_RST;
            r_max_z <= rbsi_pkg::BOX_MAX_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                rbsi_pkg::REG_MIN_X: r_min_x <= rbsi_pkg::COORD_W'(pwdata);
                rbsi_pkg::REG_MIN_Y: r_min_y <= rbsi_pkg::COORD_W'(pwdata);
                rbsi_pkg::REG_MIN_Z: r_min_z <= rbsi_pkg::COORD_W'(pwdata);
                rbsi_pkg::REG_MAX_X: r_max_x <= rbsi_pkg::COORD_W'(pwdata);
                rbsi_pkg::REG_MAX_Y: r_max_y <= rbsi_pkg::COORD_W'(pwdata);
                rbsi_pkg::REG_MAX_Z: r_max_z <= rbsi_pkg::COORD_W'(pwdata);
                default: ;  // unmapped offsets ignore the write
            endcase
        end
    end

    // readback
    always_comb begin
        unique case (cfg_idx)
            rbsi_pkg::REG_MIN_X: prdata = rbsi_pkg::DATA_W'(r_min_x);
            rbsi_pkg::REG_MIN_Y: prdata = rbsi_pkg::DATA_W'(r_min_y);
            rbsi_pkg::REG_MIN_Z: prdata = rbsi_pkg::DATA_W'(r_min_z);
            rbsi_pkg::REG_MAX_X: prdata = rbsi_pkg::DATA_W'(r_max_x);
            rbsi_pkg::REG_MAX_Y: prdata = rbsi_pkg::DATA_W'(r_max_y);
            rbsi_pkg::REG_MAX_Z: prdata = rbsi_pkg::DATA_W'(r_max_z);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or its successor
    // loads, so bubbles collapse and a stall holds only full stages
    // ------------------------------------------------------------------
    logic [NS-1:0] r_v, n_v;
    logic [NS:0]   rdy;

    always_comb begin
        rdy[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign n_v = (rdy[NS-1:0] & {r_v[NS-2:0], i_in_valid}) | (~rdy[NS-1:0] & r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_v[NS-1];

    // ------------------------------------------------------------------
    // per-axis slab distances
    // ------------------------------------------------------------------
    rbsi_pkg::t_dist near_x, far_x, near_y, far_y, near_z, far_z;

    rbsi_axis u_axis_x (
        .i_clk  (i_clk),
        .i_en   (rdy[AS-1:0]),
        .i_lo   (r_min_x),
        .i_hi   (r_max_x),
        .i_o    (i_origin_x),
        .i_d    (i_direction_x),
        .o_near (near_x),
        .o_far  (far_x)
    );

    rbsi_axis u_axis_y (
        .i_clk  (i_clk),
        .i_en   (rdy[AS-1:0]),
        .i_lo   (r_min_y),
        .i_hi   (r_max_y),
        .i_o    (i_origin_y),
        .i_d    (i_direction_y),
        .o_near (near_y),
        .o_far  (far_y)
    );

    rbsi_axis u_axis_z (
        .i_clk  (i_clk),
        .i_en   (rdy[AS-1:0]),
        .i_lo   (r_min_z),
        .i_hi   (r_max_z),
        .i_o    (i_origin_z),
        .i_d    (i_direction_z),
        .o_near (near_z),
        .o_far  (far_z)
    );

    // ------------------------------------------------------------------
    // entry is the latest near distance, exit the earliest far distance
    // ------------------------------------------------------------------
    rbsi_pkg::t_dist max_xy, min_xy, r_enter, r_exit;

    assign max_xy = (near_y > near_x) ? near_y : near_x;
    assign min_xy = (far_y < far_x) ? far_y : far_x;

    always_ff @(posedge i_clk) begin
        if (rdy[AS]) begin
            r_enter <= (near_z > max_xy) ? near_z : max_xy;
            r_exit  <= (far_z < min_xy) ? far_z : min_xy;
        end
    end

    // output register; exit above zero means at least one lsb ahead
    rbsi_pkg::t_dist r_out_enter, r_out_exit;
    logic            r_out_hit;

    always_ff @(posedge i_clk) begin
        if (rdy[AS+1]) begin
            r_out_hit   <= (r_enter < r_exit) && (r_exit > rbsi_pkg::t_dist'(0));
            r_out_enter <= r_enter;
            r_out_exit  <= r_exit;
        end
    end

    assign o_hit     = r_out_hit;
    assign o_t_enter = r_out_enter;
    assign o_t_exit  = r_out_exit;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `RBSI_ASSERT(a_hit_order, i_clk, i_rst_n, o_out_valid && o_hit |-> o_t_enter < o_t_exit, "hit with entry not before exit")
    `RBSI_ASSERT(a_hit_ahead, i_clk, i_rst_n, o_out_valid && o_hit |-> o_t_exit > 0, "hit with exit behind origin")
    `RBSI_ASSERT(a_accept_fills, i_clk, i_rst_n, i_in_valid && o_in_ready |=> r_v[0], "accepted word not in first stage")
    `RBSI_ASSERT(a_full_when_busy, i_clk, i_rst_n, !o_in_ready |-> r_v == {NS{1'b1}}, "input refused with a free stage")
    `RBSI_ASSERT_ALWAYS(a_empty_after_rst, i_clk, !i_rst_n |=> !o_out_valid, "output valid right after reset")

endmodule
